// File: sv/swmm_pkg.sv
package swmm_pkg;

    // field widths
    localparam int DATA_W = 16;
    localparam int CNT_W  = 8;

    // default window length
    localparam int SWMM_WINDOW = 128;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

endpackage

// File: sv/swmm_ring.sv
module swmm_ring
    import swmm_pkg::*;
#(
    parameter int DEPTH = SWMM_WINDOW,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    // sample storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry written flags, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: sv/sliding_window_min_max_tracker_top.sv
// flow: an accepted beat passes S_EVICT and, when a count drops to zero, a rescan in S_SCAN,
// before S_DONE loads it into the output register once that register is free
// s_tready is high only in S_IDLE, so no new beat is taken until the last one is loaded;
// the rescan reads every ring entry once through the single ring read port
// reset: the ring reads as zeros, minimum is 0 with count WINDOW, maximum is 1 with count 0
module sliding_window_min_max_tracker_top
    import swmm_pkg::*;
#(
    parameter int WINDOW = SWMM_WINDOW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // sample[15:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // window_min[15:0], min_count[23:16],
                                           // window_max[39:24], max_count[47:40]
);

    localparam int AW = $clog2(WINDOW);
    localparam int IW = $clog2(WINDOW + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVICT = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0]  min_cnt_reg, min_cnt_next;
    logic [DATA_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]  max_cnt_reg, max_cnt_next;
    logic              need_min_reg, need_min_next;
    logic              need_max_reg, need_max_next;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              accept;
    logic [DATA_W-1:0] sample;
    logic              ring_rd_en;
    logic [AW-1:0]     ring_rd_addr;
    logic [DATA_W-1:0] ring_rd_data;
    logic              ring_wr_en;
    logic [CNT_W-1:0]  min_dec;
    logic [CNT_W-1:0]  max_dec;
    logic              scan_first;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[DATA_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign min_dec    = min_cnt_reg - CNT_W'(1);
    assign max_dec    = max_cnt_reg - CNT_W'(1);
    assign scan_first = (scan_idx_reg == IW'(1));

    // ring read port: evicted entry on accept, sequential sweep while scanning
    always_comb
    begin
        ring_rd_en   = 1'b0;
        ring_rd_addr = slot_reg;
        if (accept)
        begin
            ring_rd_en = 1'b1;
        end
        else if (state_reg == S_SCAN && scan_idx_reg < IW'(WINDOW))
        begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = scan_idx_reg[AW-1:0];
        end
    end

    assign ring_wr_en = (state_reg == S_EVICT);

    swmm_ring #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data),
        .wr_en   (ring_wr_en),
        .wr_addr (slot_reg),
        .wr_data (cur_reg)
    );

    // sequencer and shared compare unit
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        slot_next     = slot_reg;
        min_next      = min_reg;
        min_cnt_next  = min_cnt_reg;
        max_next      = max_reg;
        max_cnt_next  = max_cnt_reg;
        need_min_next = need_min_reg;
        need_max_next = need_max_reg;
        scan_idx_next = scan_idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // output beat taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = sample;
                    // equality uses the old extrema, replacement follows
                    if (sample == min_reg)
                    begin
                        min_cnt_next = min_cnt_reg + CNT_W'(1);
                    end
                    if (sample < min_reg)
                    begin
                        min_next     = sample;
                        min_cnt_next = CNT_W'(1);
                    end
                    if (sample == max_reg)
                    begin
                        max_cnt_next = max_cnt_reg + CNT_W'(1);
                    end
                    if (sample > max_reg)
                    begin
                        max_next     = sample;
                        max_cnt_next = CNT_W'(1);
                    end
                    state_next = S_EVICT;
                end
            end

            S_EVICT:
            begin
                // ring write of the new sample happens this cycle
                slot_next     = (slot_reg == '0) ? AW'(WINDOW - 1) : slot_reg - AW'(1);
                need_min_next = 1'b0;
                need_max_next = 1'b0;
                if (ring_rd_data == min_reg)
                begin
                    min_cnt_next  = min_dec;
                    need_min_next = (min_dec == '0);
                end
                if (ring_rd_data == max_reg)
                begin
                    max_cnt_next  = max_dec;
                    need_max_next = (max_dec == '0);
                end
                scan_idx_next = '0;
                if ((ring_rd_data == min_reg && min_dec == '0) ||
                    (ring_rd_data == max_reg && max_dec == '0))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN:
            begin
                // data of entry scan_idx - 1 arrives now
                if (scan_idx_reg != '0)
                begin
                    if (need_min_reg)
                    begin
                        if (scan_first || ring_rd_data < min_reg)
                        begin
                            min_next     = ring_rd_data;
                            min_cnt_next = CNT_W'(1);
                        end
                        else if (ring_rd_data == min_reg)
                        begin
                            min_cnt_next = min_cnt_reg + CNT_W'(1);
                        end
                    end
                    if (need_max_reg)
                    begin
                        if (scan_first || ring_rd_data > max_reg)
                        begin
                            max_next     = ring_rd_data;
                            max_cnt_next = CNT_W'(1);
                        end
                        else if (ring_rd_data == max_reg)
                        begin
                            max_cnt_next = max_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                if (scan_idx_reg == IW'(WINDOW))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end

            S_DONE:
            begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {max_cnt_reg, max_reg, min_cnt_reg, min_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and tracked extrema
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            slot_reg     <= AW'(WINDOW - 1);
            min_reg      <= '0;
            min_cnt_reg  <= CNT_W'(WINDOW);
            max_reg      <= DATA_W'(1);
            max_cnt_reg  <= '0;
            need_min_reg <= 1'b0;
            need_max_reg <= 1'b0;
            scan_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            min_reg      <= min_next;
            min_cnt_reg  <= min_cnt_next;
            max_reg      <= max_next;
            max_cnt_reg  <= max_cnt_next;
            need_min_reg <= need_min_next;
            need_max_reg <= need_max_next;
            scan_idx_reg <= scan_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
    end

    // accepted beat always moves on to the eviction step
    a_accept_to_evict: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EVICT)
        else $error("accepted beat did not reach eviction step");

    // write slot stays inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < AW'(WINDOW) || WINDOW == (1 << AW))
        else $error("write slot out of window range");

    // scan index never runs past the window
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= IW'(WINDOW))
        else $error("scan index past window");

    // a finished minimum rescan leaves a nonzero count
    a_min_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && scan_idx_reg == IW'(WINDOW) && need_min_reg
        |=> min_cnt_reg != '0)
        else $error("minimum rescan left zero count");

    // a finished maximum rescan leaves a nonzero count
    a_max_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && scan_idx_reg == IW'(WINDOW) && need_max_reg
        |=> max_cnt_reg != '0)
        else $error("maximum rescan left zero count");

endmodule

// File: sim/swmm_extrema_checker.sv
`timescale 1ns / 1ps

module swmm_extrema_checker
    import swmm_pkg::*;
#(
    parameter int WINDOW = SWMM_WINDOW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample[15:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // window_min[15:0], min_count[23:16],
                                            // window_max[39:24], max_count[47:40]
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [DATA_W-1:0] lo;
        logic [CNT_W-1:0]  lo_cnt;
        logic [DATA_W-1:0] hi;
        logic [CNT_W-1:0]  hi_cnt;
    } extrema_t;

    // shadow copy of the window and the tracked extrema
    logic [DATA_W-1:0] ring [WINDOW];
    int unsigned       slot;
    logic [DATA_W-1:0] lo_val;
    logic [CNT_W-1:0]  lo_cnt;
    logic [DATA_W-1:0] hi_val;
    logic [CNT_W-1:0]  hi_cnt;

    extrema_t window_stats_q [$];
    int       mismatches;

    // full pass over the window for the minimum and its multiplicity
    function automatic void rescan_low();
        logic [DATA_W-1:0] best;
        logic [CNT_W-1:0]  n;
        int                k;
        best = ring[0];
        n    = CNT_W'(1);
        for (k = 1; k < WINDOW; k++)
        begin
            if (ring[k] < best)
            begin
                best = ring[k];
                n    = CNT_W'(1);
            end
            else if (ring[k] == best)
                n = n + 1'b1;
        end
        lo_val = best;
        lo_cnt = n;
    endfunction

    // full pass over the window for the maximum and its multiplicity
    function automatic void rescan_high();
        logic [DATA_W-1:0] best;
        logic [CNT_W-1:0]  n;
        int                k;
        best = ring[0];
        n    = CNT_W'(1);
        for (k = 1; k < WINDOW; k++)
        begin
            if (ring[k] > best)
            begin
                best = ring[k];
                n    = CNT_W'(1);
            end
            else if (ring[k] == best)
                n = n + 1'b1;
        end
        hi_val = best;
        hi_cnt = n;
    endfunction

    // push one sample into the window and return the extrema after the update
    function automatic extrema_t advance_window(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] gone;
        extrema_t          r;
        // equality checks against the old extrema come first
        if (v == lo_val)
            lo_cnt = lo_cnt + 1'b1;
        if (v == hi_val)
            hi_cnt = hi_cnt + 1'b1;
        if (v > hi_val)
        begin
            hi_val = v;
            hi_cnt = CNT_W'(1);
        end
        if (v < lo_val)
        begin
            lo_val = v;
            lo_cnt = CNT_W'(1);
        end
        // ring write, slot moves downward and wraps
        gone       = ring[slot];
        ring[slot] = v;
        slot       = (slot == 0) ? WINDOW - 1 : slot - 1;
        // evicted sample; a count wrapping below zero does not rescan
        if (gone == lo_val)
        begin
            lo_cnt = lo_cnt - 1'b1;
            if (lo_cnt == 0)
                rescan_low();
        end
        if (gone == hi_val)
        begin
            hi_cnt = hi_cnt - 1'b1;
            if (hi_cnt == 0)
                rescan_high();
        end
        r.lo     = lo_val;
        r.lo_cnt = lo_cnt;
        r.hi     = hi_val;
        r.hi_cnt = hi_cnt;
        return r;
    endfunction

    // watch both channels, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        extrema_t want;
        extrema_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
                ring[k] = '0;
            slot   = WINDOW - 1;
            lo_val = '0;
            lo_cnt = CNT_W'(WINDOW);
            hi_val = DATA_W'(1);
            hi_cnt = '0;
            window_stats_q.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.lo     = m_tdata[15:0];
                got.lo_cnt = m_tdata[23:16];
                got.hi     = m_tdata[39:24];
                got.hi_cnt = m_tdata[47:40];
                if (window_stats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: min %0d/%0d max %0d/%0d",
                                 got.lo, got.lo_cnt, got.hi, got.hi_cnt);
                end
                else
                begin
                    want = window_stats_q.pop_front();
                    if (got.lo != want.lo || got.lo_cnt != want.lo_cnt ||
                        got.hi != want.hi || got.hi_cnt != want.hi_cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d %0d/%0d, got %0d/%0d %0d/%0d",
                                     want.lo, want.lo_cnt, want.hi, want.hi_cnt,
                                     got.lo, got.lo_cnt, got.hi, got.hi_cnt);
                    end
                end
            end
            if (s_tvalid && s_tready)
                window_stats_q.push_back(advance_window(s_tdata[DATA_W-1:0]));
            errors  <= mismatches;
            pending <= window_stats_q.size();
        end
    end

endmodule

// File: sim/sliding_window_min_max_tracker_top_test.sv
`timescale 1ns / 1ps

module sliding_window_min_max_tracker_top_test;
    import swmm_pkg::*;

    localparam int WINDOW       = SWMM_WINDOW;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_LIMIT  = 4000;

    // shapes of the random sample stream
    typedef enum logic [2:0] {
        PAT_CLUSTER,
        PAT_WIDE,
        PAT_RISE,
        PAT_FALL,
        PAT_EXTREME
    } pattern_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   errors;
    int                   pending;
    int                   quiet = 0;
    int                   burst_left = 0;

    always #1 clk = ~clk;

    sliding_window_min_max_tracker_top #(
        .WINDOW (WINDOW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    swmm_extrema_checker #(
        .WINDOW (WINDOW)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // receiver: runs of ready, runs of stall and short choppy stretches
    initial
    begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        m_tready <= 1'b0;
                        hold = $urandom_range(1, 10);
                    end
                    1:
                    begin
                        m_tready <= 1'b1;
                        hold = $urandom_range(20, 60);
                    end
                    default:
                    begin
                        m_tready <= 1'($urandom_range(0, 1));
                        hold = $urandom_range(0, 3);
                    end
                endcase
            end
            else
                hold = hold - 1;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one input beat, with a random gap between bursts
    task automatic send_sample(input logic [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [DATA_W-1:0] directed [$];
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] stride;
        pattern_e          pat;
        int                seg_left;
        int                n;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero first while the maximum still sits at its reset value,
        // then equal-to-extremum, new extremes and alternating bit patterns
        directed = '{16'h0000, 16'h0001, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFF,
                     16'h0000, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                     16'h00FF, 16'hFF00, 16'h0001, 16'h0000, 16'hFFFF, 16'h1234,
                     16'h0000, 16'hFFFF};
        foreach (directed[i])
            send_sample(directed[i]);

        // random segments of clustered, wide, ramping and extreme samples
        seg_left = 0;
        v        = '0;
        base     = '0;
        stride   = DATA_W'(1);
        pat      = PAT_WIDE;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                pat      = pattern_e'($urandom_range(0, 4));
                seg_left = $urandom_range(8, 64);
                base     = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 8))
                                                : DATA_W'($urandom);
                stride   = DATA_W'($urandom_range(1, 300));
                v        = base;
            end
            seg_left = seg_left - 1;
            case (pat)
                PAT_CLUSTER: v = base + DATA_W'($urandom_range(0, 3));
                PAT_WIDE:    v = DATA_W'($urandom);
                PAT_RISE:    v = v + stride;
                PAT_FALL:    v = v - stride;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = '0;
                        1:       v = '1;
                        2:       v = 16'h0001;
                        default: v = DATA_W'($urandom);
                    endcase
                end
            endcase
            send_sample(v);
        end

        // drain, then allow a full rescan for anything still in flight
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (WINDOW + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
